// ===== hw/rtl/wpft_pkg.sv =====
package wpft_pkg;

	localparam int ALPHABET_SIZE_DEF = 21;

	localparam int REQ_W    = 2;
	localparam int CODE_W   = 5;
	localparam int WEIGHT_W = 17;
	localparam int INIT_W   = 32;
	localparam int RECIP_W  = 24;
	localparam int CELL_W   = 40;
	localparam int HALF_W   = CELL_W / 2;
	localparam int FREQ_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = REQ_W;
	localparam int OUT_DATA_W = FREQ_W;
	localparam int OUT_USER_W = 1;

	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 2'd1;

	typedef struct packed {
		logic cap;
		logic clr_wr;
		logic add_rd;
		logic add_wr;
		logic rd_rd;
		logic rd_mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic codes_ok;
		logic clr_done;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/wpft_ram.sv =====
module wpft_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 441
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/wpft_ctrl.sv =====
module wpft_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [wpft_pkg::REQ_W-1:0] req,
	input  wpft_pkg::status_t         status,
	output wpft_pkg::cmd_t            cmd
);

	import wpft_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_ADD_R = 3'd2;
	localparam logic [2:0] ST_ADD_W = 3'd3;
	localparam logic [2:0] ST_RD_M  = 3'd4;
	localparam logic [2:0] ST_RD_P  = 3'd5;
	localparam logic [2:0] ST_RD_O  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cap = acc;
				if (acc) begin
					priority if (req == REQ_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (req == REQ_ADD && status.codes_ok) begin
						state_d = ST_ADD_R;
					end else if (req == REQ_READ && status.codes_ok) begin
						state_d = ST_RD_M;
					end else if (req == REQ_READ) begin
						state_d = ST_RD_O;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ADD_R: begin
				cmd.add_rd = 1'b1;
				state_d    = ST_ADD_W;
			end
			ST_ADD_W: begin
				cmd.add_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RD_M: begin
				cmd.rd_rd = 1'b1;
				state_d   = ST_RD_P;
			end
			ST_RD_P: begin
				cmd.rd_mul = 1'b1;
				state_d    = ST_RD_O;
			end
			ST_RD_O: begin
				// hold until the output slot is free
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/wpft_dp.sv =====
module wpft_dp #(
	parameter int ALPHABET_SIZE = wpft_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [wpft_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wpft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpft_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wpft_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [wpft_pkg::OUT_USER_W-1:0] m_tuser,
	input  wpft_pkg::cmd_t                  cmd,
	output wpft_pkg::status_t               status
);

	import wpft_pkg::*;

	localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = HALF_W + RECIP_W;
	localparam int SUM_W  = CELL_W + RECIP_W;

	logic [CODE_W-1:0]   in_a;
	logic [CODE_W-1:0]   in_b;
	logic [WEIGHT_W-1:0] in_w;
	logic                in_ok;
	logic [ADDR_W+CODE_W-1:0] in_addr_wide;

	logic [ADDR_W-1:0]   addr_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                bad_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [INIT_W-1:0]   init_q;
	logic [RECIP_W-1:0]  recip_q;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [CELL_W-1:0]   mem_rdata;

	logic [CELL_W:0]     add_sum;
	logic [CELL_W-1:0]   add_sat;

	logic [PROD_W-1:0]   ph_s2;
	logic [PROD_W-1:0]   pl_s2;
	logic [SUM_W-1:0]    prod;
	logic [FREQ_W-1:0]   freq_sat;

	logic                m_valid_q;
	logic [FREQ_W-1:0]   freq_q;
	logic                bad_out_q;

	// tdata: residue_a, residue_b, weight from bit 0 up
	assign in_a = s_tdata[CODE_W-1:0];
	assign in_b = s_tdata[2*CODE_W-1:CODE_W];
	assign in_w = s_tdata[2*CODE_W+WEIGHT_W-1:2*CODE_W];

	assign in_ok = ({1'b0, in_a} < (CODE_W+1)'(ALPHABET_SIZE))
		&& ({1'b0, in_b} < (CODE_W+1)'(ALPHABET_SIZE));
	assign in_addr_wide = (ADDR_W+CODE_W)'(in_a) * (ADDR_W+CODE_W)'(ALPHABET_SIZE)
		+ (ADDR_W+CODE_W)'(in_b);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			addr_q   <= in_addr_wide[ADDR_W-1:0];
			weight_q <= in_w;
			bad_q    <= !in_ok;
		end
	end

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cap) begin
			cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			recip_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_INIT) begin
				init_q <= cfg_data[INIT_W-1:0];
			end
			if (cfg_index == CFG_RECIP) begin
				recip_q <= cfg_data[RECIP_W-1:0];
			end
		end
	end

	assign add_sum = {1'b0, mem_rdata} + (CELL_W+1)'(weight_q);
	assign add_sat = add_sum[CELL_W] ? {CELL_W{1'b1}} : add_sum[CELL_W-1:0];

	assign mem_we    = cmd.clr_wr || cmd.add_wr;
	assign mem_waddr = cmd.clr_wr ? cnt_q : addr_q;
	assign mem_wdata = cmd.clr_wr ? CELL_W'(init_q) : add_sat;
	assign mem_re    = cmd.add_rd || cmd.rd_rd;

	wpft_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	// cell times reciprocal as two half-width products
	always_ff @(posedge clk) begin
		if (cmd.rd_mul) begin
			ph_s2 <= mem_rdata[CELL_W-1:HALF_W] * recip_q;
			pl_s2 <= mem_rdata[HALF_W-1:0] * recip_q;
		end
	end

	assign prod     = {ph_s2, {HALF_W{1'b0}}} + SUM_W'(pl_s2);
	assign freq_sat = (|prod[SUM_W-1:RECIP_W+FREQ_W]) ? {FREQ_W{1'b1}}
		: prod[RECIP_W+FREQ_W-1:RECIP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			freq_q    <= bad_q ? '0 : freq_sat;
			bad_out_q <= bad_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = freq_q;
	assign m_tuser  = bad_out_q;

	assign status.codes_ok = in_ok;
	assign status.clr_done = (cnt_q == ADDR_W'(DEPTH - 1));
	assign status.out_free = !m_valid_q || m_tready;

endmodule

// ===== hw/rtl/weighted_pair_frequency_table.sv =====
// weighted joint-frequency table for one pair of alignment columns
// input stream: s_tuser carries the request kind (clear, add, read), s_tdata the
// two residue codes and the Q1.16 weight; one request is worked at a time
// config channel: cfg_index 0 loads init_value, 1 loads norm_reciprocal; always
// ready, write only while no request is in progress
// clear: fills all ALPHABET_SIZE^2 cells with init_value, one cell a cycle from
// the single ram write port
// add: read-modify-write of one ram cell, a read state and a saturating write state
// add with a bad code or request code 3: dropped, ready again next cycle
// read: registered ram read, two registered 20x24 products, sum and saturate;
// a free output register takes the result; a bad code skips straight to this load
// output stream: m_tdata frequency in Q0.16, m_tuser bad_code flag
// a stalled receiver holds the result in the output register; the next request
// is still taken and only a following read waits for the slot
// reset clears the controller, output valid and both config registers; the
// cell memory is not cleared, so a clear request must come before any read
module weighted_pair_frequency_table #(
	parameter int ALPHABET_SIZE = wpft_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wpft_pkg::IN_DATA_W-1:0]  s_tdata,  // residue_a, residue_b, weight
	input  logic [wpft_pkg::IN_USER_W-1:0]  s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wpft_pkg::OUT_DATA_W-1:0] m_tdata,  // frequency
	output logic [wpft_pkg::OUT_USER_W-1:0] m_tuser,  // bad_code
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wpft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpft_pkg::CFG_DATA_W-1:0] cfg_data
);

	import wpft_pkg::*;

	cmd_t    cmd;
	status_t status;

	wpft_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.req     (s_tuser),
		.status  (status),
		.cmd     (cmd)
	);

	wpft_dp #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.status   (status)
	);

endmodule
